[design/ckl_pkg.sv]
// shared types, codes and defaults for the compacting key list
`default_nettype none
package ckl_pkg;

	localparam int CAPACITY_DEF = 128;

	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_REMOVE = 2'd1;
	localparam logic [1:0] ACT_FIND   = 2'd2;

	localparam logic [1:0] ST_DONE   = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_ABSENT = 2'd2;

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] key;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [6:0] position;
		logic [7:0] fill_count;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_SCAN,
		S_SHIFT,
		S_RESP
	} state_t;

	typedef struct packed {
		logic take_req;
		logic do_insert;
		logic set_full;
		logic set_noop;
		logic scan_start;
		logic issue;
		logic set_found;
		logic set_absent;
		logic shift_start;
		logic shift_wr;
		logic dec_count;
		logic load_rsp;
	} cmd_t;

	typedef struct packed {
		logic [1:0] action;
		logic       full;
		logic       hit;
		logic       idx_lt_cnt;
		logic       rd_pend;
		logic       out_free;
	} sts_t;

endpackage
`default_nettype wire

[design/compacting_key_list.sv]
// top level of the compacting key list: controller plus datapath
// An ordered list of 16-bit connection keys held in a single-port-write,
// single-port-read memory of CAPACITY entries, with a fill count. Insert
// appends a key at the end (status full when the list holds CAPACITY keys),
// find returns the position of the first equal key, and remove finds the
// first equal key, moves every later key down one place and decrements the
// count; absent keys give status not found with position zero. Every result
// word carries the fill count after the operation. One request word is
// worked at a time; find and remove walk the memory with one entry read
// per cycle (the shift overlaps one read and one write per cycle). The result
// sits in an output register, so a new request is taken while the previous
// result waits.
// Memory contents need no clearing after reset; only entries below the count
// are ever read.
`default_nettype none
module compacting_key_list #(
	parameter int CAPACITY = ckl_pkg::CAPACITY_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	// request channel
	input  wire logic          req_valid,
	output      logic          req_stall,
	input  wire ckl_pkg::req_t req,
	// result channel
	output      logic          rsp_valid,
	input  wire logic          rsp_stall,
	output      ckl_pkg::rsp_t rsp
);
	import ckl_pkg::*;

	// command and status bundles between controller and datapath
	cmd_t cmd;
	sts_t sts;

	// sequencing: dispatch, key scan, compacting shift, result hand-off
	ckl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// key memory, count, walk index and output word register
	ckl_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire

[design/ckl_dpath.sv]
// datapath: entry memory, fill count, walk index and result register
`default_nettype none
module ckl_dpath #(
	parameter int CAPACITY = ckl_pkg::CAPACITY_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire ckl_pkg::req_t req,
	input  wire ckl_pkg::cmd_t cmd,
	output      ckl_pkg::sts_t sts,
	output      logic          rsp_valid,
	input  wire logic         rsp_stall,
	output      ckl_pkg::rsp_t rsp
);
	import ckl_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic [15:0]   entry_mem_q [CAPACITY];
	logic [1:0]    act_q;
	logic [15:0]   key_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic          rd_vld_s1;
	logic [AW-1:0] chk_idx_s1;
	logic [15:0]   rdata_s1;
	logic [1:0]    res_status_q;
	logic [AW-1:0] res_pos_q;
	logic          out_valid_q;
	rsp_t          out_q;

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [15:0]   wr_data;

	// insert appends at the count, shift moves the word just read down one place
	assign wr_en   = cmd.do_insert | cmd.shift_wr;
	assign wr_addr = cmd.do_insert ? count_q[AW-1:0] : chk_idx_s1 - AW'(1);
	assign wr_data = cmd.do_insert ? key_q : rdata_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_mem_q[wr_addr] <= wr_data;
		end
		if (cmd.issue) begin
			rdata_s1   <= entry_mem_q[idx_q[AW-1:0]];
			chk_idx_s1 <= idx_q[AW-1:0];
		end
		if (cmd.take_req) begin
			act_q <= req.action;
			key_q <= req.key;
		end
		if (cmd.do_insert) begin
			res_status_q <= ST_DONE;
			res_pos_q    <= count_q[AW-1:0];
		end else if (cmd.set_full) begin
			res_status_q <= ST_FULL;
			res_pos_q    <= '0;
		end else if (cmd.set_found) begin
			res_status_q <= ST_DONE;
			res_pos_q    <= chk_idx_s1;
		end else if (cmd.set_absent) begin
			res_status_q <= ST_ABSENT;
			res_pos_q    <= '0;
		end else if (cmd.set_noop) begin
			res_status_q <= ST_DONE;
			res_pos_q    <= '0;
		end
		if (cmd.load_rsp) begin
			out_q.status     <= res_status_q;
			out_q.position   <= 7'(res_pos_q);
			out_q.fill_count <= 8'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			idx_q       <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.issue;
			if (cmd.do_insert) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.dec_count) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.scan_start) begin
				idx_q <= '0;
			end else if (cmd.shift_start) begin
				idx_q <= CW'(chk_idx_s1) + CW'(1);
			end else if (cmd.issue) begin
				idx_q <= idx_q + CW'(1);
			end
			if (cmd.load_rsp) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		sts.action     = act_q;
		sts.full       = (count_q == CW'(CAPACITY));
		sts.hit        = rd_vld_s1 && (rdata_s1 == key_q);
		sts.idx_lt_cnt = (idx_q < count_q);
		sts.rd_pend    = rd_vld_s1;
		sts.out_free   = !out_valid_q || !rsp_stall;
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("fill count above capacity");

	a_read_live: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (CW'(chk_idx_s1) < count_q))
		else $error("read of an entry at or above the count");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |->
			((count_q == $past(count_q) + CW'(1)) || (count_q == $past(count_q) - CW'(1))))
		else $error("fill count moved by more than one");

	a_rsp_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_rsp |-> (!out_valid_q || !rsp_stall))
		else $error("result loaded over a word not yet taken");

endmodule
`default_nettype wire

[design/ckl_ctrl.sv]
// controller state machine for insert, scan and shift sequencing
`default_nettype none
module ckl_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output      logic          req_stall,
	input  wire ckl_pkg::sts_t sts,
	output      ckl_pkg::cmd_t cmd
);
	import ckl_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_nxt = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (sts.action)
					ACT_REMOVE, ACT_FIND: state_nxt = S_SCAN;
					default:              state_nxt = S_RESP;
				endcase
			end
			S_SCAN: begin
				if (sts.hit) begin
					state_nxt = (sts.action == ACT_REMOVE) ? S_SHIFT : S_RESP;
				end else if (!sts.idx_lt_cnt && !sts.rd_pend) begin
					state_nxt = S_RESP;
				end
			end
			S_SHIFT: begin
				if (!sts.idx_lt_cnt && !sts.rd_pend) begin
					state_nxt = S_RESP;
				end
			end
			S_RESP: begin
				if (sts.out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd       = '0;
		req_stall = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: begin
				cmd.take_req = req_valid;
			end
			S_DISPATCH: begin
				case (sts.action)
					ACT_INSERT: begin
						cmd.do_insert = !sts.full;
						cmd.set_full  = sts.full;
					end
					ACT_REMOVE, ACT_FIND: cmd.scan_start = 1'b1;
					default:              cmd.set_noop   = 1'b1;
				endcase
			end
			S_SCAN: begin
				if (sts.hit) begin
					cmd.set_found   = 1'b1;
					cmd.shift_start = (sts.action == ACT_REMOVE);
				end else if (sts.idx_lt_cnt) begin
					cmd.issue = 1'b1;
				end else if (!sts.rd_pend) begin
					cmd.set_absent = 1'b1;
				end
			end
			S_SHIFT: begin
				cmd.issue     = sts.idx_lt_cnt;
				cmd.shift_wr  = sts.rd_pend;
				cmd.dec_count = !sts.idx_lt_cnt && !sts.rd_pend;
			end
			S_RESP: begin
				cmd.load_rsp = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule
`default_nettype wire

[verif/compacting_key_list_tb.sv]
// self-checking testbench for compacting_key_list: directed table, then random traffic
module compacting_key_list_tb;
	import ckl_pkg::*;

	// list size used by the instance and by the local list model
	localparam int CAP = CAPACITY_DEF;
	// action code three is not an operation; the block answers with the count only
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	// cycles without any accepted word before the run is declared hung;
	// the slowest word is a remove on a full list, and the long receiver
	// hold-off below is far shorter than this limit
	localparam int WATCHDOG_LIMIT = 4000;
	// length of the receiver hold-off that backs the block up
	localparam int HOLD_CYCLES = 600;
	// quiet cycles after the last result, covers one full-list walk
	localparam int TAIL_CYCLES = 200;

	// one row of the directed table; typed rows carry the result read off by hand
	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] key;
		logic        typed;
		logic [1:0]  status;
		logic [6:0]  position;
		logic [7:0]  fill_count;
	} dir_row_t;

	// a request word waiting to be offered, with its hand-typed result if any
	typedef struct {
		req_t word;
		bit   typed;
		rsp_t want;
	} pending_word_t;

	// directed part: empty list, extremes of the key, duplicates, first-match
	// rules, remove of the first and of the last entry, absent keys, unused code
	localparam dir_row_t DIRECTED [18] = '{
		'{ACT_FIND,   16'h1234, 1'b1, ST_ABSENT, 7'd0, 8'd0},
		'{ACT_REMOVE, 16'hFFFF, 1'b1, ST_ABSENT, 7'd0, 8'd0},
		'{ACT_UNUSED, 16'hAAAA, 1'b1, ST_DONE,   7'd0, 8'd0},
		'{ACT_INSERT, 16'h0000, 1'b1, ST_DONE,   7'd0, 8'd1},
		'{ACT_INSERT, 16'hFFFF, 1'b1, ST_DONE,   7'd1, 8'd2},
		'{ACT_INSERT, 16'h0000, 1'b1, ST_DONE,   7'd2, 8'd3},
		'{ACT_INSERT, 16'h5A5A, 1'b1, ST_DONE,   7'd3, 8'd4},
		'{ACT_FIND,   16'h0000, 1'b1, ST_DONE,   7'd0, 8'd4},
		'{ACT_FIND,   16'hFFFF, 1'b1, ST_DONE,   7'd1, 8'd4},
		'{ACT_FIND,   16'h5A5A, 1'b1, ST_DONE,   7'd3, 8'd4},
		'{ACT_REMOVE, 16'h0000, 1'b1, ST_DONE,   7'd0, 8'd3},
		'{ACT_FIND,   16'h0000, 1'b1, ST_DONE,   7'd1, 8'd3},
		'{ACT_FIND,   16'h5A5A, 1'b1, ST_DONE,   7'd2, 8'd3},
		'{ACT_REMOVE, 16'h5A5A, 1'b1, ST_DONE,   7'd2, 8'd2},
		'{ACT_REMOVE, 16'h1111, 1'b1, ST_ABSENT, 7'd0, 8'd2},
		'{ACT_UNUSED, 16'h5555, 1'b1, ST_DONE,   7'd0, 8'd2},
		'{ACT_INSERT, 16'hA5A5, 1'b0, ST_DONE,   7'd0, 8'd0},
		'{ACT_FIND,   16'hA5A5, 1'b0, ST_DONE,   7'd0, 8'd0}
	};

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	// local copy of the list: keys in order and the fill count
	logic [15:0]   list_keys [CAP];
	int            list_count;

	// words not yet offered, the word on the bus, results still to arrive
	pending_word_t send_q[$];
	pending_word_t offered;
	rsp_t          results_due[$];

	// idling odds in percent, set per phase by the stimulus process
	int            send_idle_pct;
	int            stall_pct;
	// hold-off request to the receiver and its own countdown
	bit            hold_req;
	int            hold_left;

	int            mismatches;
	int            quiet_cycles;
	logic [15:0]   key_pool [16];

	compacting_key_list i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// apply one request word to the local list and return the result word
	function automatic rsp_t apply_to_list(req_t w);
		rsp_t r;
		int   hit;
		r = '{ST_DONE, 7'd0, 8'd0};
		hit = -1;
		// first match only, and only entries below the count
		for (int i = 0; i < list_count; i++)
			if (hit < 0 && list_keys[i] == w.key)
				hit = i;
		case (w.action)
		ACT_INSERT: begin
			if (list_count >= CAP) begin
				r.status = ST_FULL;
			end else begin
				list_keys[list_count] = w.key;
				r.position = 7'(list_count);
				list_count++;
			end
		end
		ACT_REMOVE: begin
			if (hit < 0) begin
				r.status = ST_ABSENT;
			end else begin
				r.position = 7'(hit);
				// close the gap so that the order is kept
				for (int i = hit; i + 1 < list_count; i++)
					list_keys[i] = list_keys[i + 1];
				list_count--;
			end
		end
		ACT_FIND: begin
			if (hit < 0)
				r.status = ST_ABSENT;
			else
				r.position = 7'(hit);
		end
		default: begin
		end
		endcase
		r.fill_count = 8'(list_count);
		return r;
	endfunction

	task automatic check_field(string field_name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field_name, want, got);
			mismatches++;
		end
	endtask

	task automatic queue_word(req_t w, bit typed, rsp_t want);
		pending_word_t p;
		p.word = w;
		p.typed = typed;
		p.want = want;
		send_q.push_back(p);
	endtask

	// mostly keys from a small pool so that finds and removes hit, with the
	// two key extremes always in it; a share of fully random keys for bit toggles
	task automatic refresh_pool();
		key_pool[0] = 16'h0000;
		key_pool[1] = 16'hFFFF;
		for (int i = 2; i < 16; i++)
			key_pool[i] = 16'($urandom);
	endtask

	function automatic logic [15:0] pick_key();
		if ($urandom_range(99) < 80)
			return key_pool[$urandom_range(15)];
		return 16'($urandom);
	endfunction

	// random mix of operations, weights in percent for insert and remove
	task automatic queue_random(int n, int ins_pct, int rem_pct);
		req_t w;
		int   r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < ins_pct)
				w.action = ACT_INSERT;
			else if (r < ins_pct + rem_pct)
				w.action = ACT_REMOVE;
			else if (r < 97)
				w.action = ACT_FIND;
			else
				w.action = ACT_UNUSED;
			w.key = pick_key();
			queue_word(w, 1'b0, '0);
		end
	endtask

	// fill past capacity (full reports at the end), look around, then drain
	task automatic queue_fill_drain();
		req_t w;
		for (int i = 0; i < CAP + 4; i++) begin
			w.action = ACT_INSERT;
			w.key = pick_key();
			queue_word(w, 1'b0, '0);
		end
		for (int i = 0; i < 20; i++) begin
			w.action = ACT_FIND;
			w.key = pick_key();
			queue_word(w, 1'b0, '0);
		end
		for (int i = 0; i < CAP + 12; i++) begin
			w.action = ACT_REMOVE;
			w.key = pick_key();
			queue_word(w, 1'b0, '0);
		end
	endtask

	// wait until every word is taken and every result has come back
	task automatic wait_all_done();
		do
			@(negedge clk);
		while (send_q.size() != 0 || req_valid || results_due.size() != 0);
	endtask

	// sender: offers queued words, idles at random, holds a stalled word
	always @(posedge clk) begin
		rsp_t predicted;
		if (arst_n) begin
			// every accepted word updates the local list, typed rows included
			if (req_valid && !req_stall) begin
				predicted = apply_to_list(offered.word);
				results_due.push_back(offered.typed ? offered.want : predicted);
			end
			// a stalled word stays on the bus untouched
			if (!req_valid || !req_stall) begin
				if (send_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					offered = send_q.pop_front();
					req_valid <= 1'b1;
					req <= offered.word;
				end else begin
					// payload is free to wander while valid is low
					req_valid <= 1'b0;
					req <= req_t'($urandom);
				end
			end
		end
	end

	// receiver: checks each accepted result word, stalls at random or for a hold-off
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (results_due.size() == 0) begin
					$display("%0t: unexpected result word, got %p", $time, rsp);
					mismatches++;
				end else begin
					want = results_due.pop_front();
					check_field("status", 8'(want.status), 8'(rsp.status));
					check_field("position", 8'(want.position), 8'(rsp.position));
					check_field("fill_count", want.fill_count, rsp.fill_count);
				end
			end
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// watchdog on cycles where neither channel moves a word
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: timeout, no word moved for %0d cycles", $time, quiet_cycles);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		pending_word_t p;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		send_idle_pct = 0;
		stall_pct = 0;
		hold_req = 1'b0;
		hold_left = 0;
		mismatches = 0;
		quiet_cycles = 0;
		list_count = 0;
		refresh_pool();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed table, no idling on either side
		foreach (DIRECTED[i])
			queue_word('{DIRECTED[i].action, DIRECTED[i].key}, DIRECTED[i].typed,
				'{DIRECTED[i].status, DIRECTED[i].position, DIRECTED[i].fill_count});
		wait_all_done();

		// full list and full drain, back to back
		refresh_pool();
		queue_fill_drain();
		wait_all_done();

		// sender idles often, list tends to grow
		send_idle_pct = 58;
		queue_random(300, 60, 25);
		wait_all_done();

		// receiver stalls often, list tends to shrink
		send_idle_pct = 0;
		stall_pct = 58;
		refresh_pool();
		queue_random(300, 30, 55);
		wait_all_done();

		// both sides idle, full list again
		send_idle_pct = 23;
		stall_pct = 23;
		refresh_pool();
		queue_fill_drain();
		wait_all_done();

		queue_random(300, 45, 35);
		wait_all_done();

		// receiver holds off for a long stretch while words keep coming,
		// the block backs up and stalls its input
		send_idle_pct = 0;
		stall_pct = 0;
		hold_req = 1'b1;
		queue_random(24, 60, 20);
		// sender pauses here until every result is in
		wait_all_done();

		refresh_pool();
		queue_random(300, 50, 35);
		wait_all_done();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && results_due.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
